>>> hw/rtl/vap_pkg.sv
// ----------------------------------------------------------------------------
// vap_pkg
// Shared types and constants of the voice slot allocator: field widths,
// command and status codes, controller states and the command/status
// bundles between controller and datapath.
// ----------------------------------------------------------------------------
package vap_pkg;

	localparam int NUM_SLOTS_DEF = 96;

	localparam int CMD_W  = 2;
	localparam int PRIO_W = 32;
	localparam int SLOT_W = 8;
	localparam int STAT_W = 2;

	// request command codes
	localparam logic [CMD_W-1:0] CMD_ACQUIRE  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_FREE     = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SET_PRIO = 2'd2;

	// result status codes
	localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
	localparam logic [STAT_W-1:0] STAT_NONE = 2'd1;
	localparam logic [STAT_W-1:0] STAT_BAD  = 2'd2;

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_DECODE,
		S_ASCAN_A,
		S_ASCAN_B,
		S_ASCAN_C,
		S_FSCAN_A,
		S_FSCAN_B,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_RELEASE,
		S_GRANT_RD,
		S_GRANT,
		S_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic init_wr;
		logic load;
		logic held_rd;
		logic held_rd_next;
		logic prio_rd;
		logic pos_inc;
		logic shift_wr;
		logic set_prio;
		logic st_none;
		logic st_bad;
		logic vic_scan;
		logic vic_free;
		logic release_vic;
		logic fifo_rd;
		logic grant;
		logic res_load;
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		logic init_last;
		logic is_acquire;
		logic is_free;
		logic is_set;
		logic slot_ok;
		logic slot_held;
		logic free_empty;
		logic pos_at_end;
		logic next_at_end;
		logic prio_lt;
		logic match;
		logic out_free;
	} sts_t;

endpackage

>>> hw/rtl/voice_allocator_priority_preempt.sv
// Set priority, a rejected free and the unused command go straight to the result. An acquire
// served from the free FIFO reads it and grants; a free scans the held list for its slot, then
// compacts and releases; a preempting acquire scans, compacts, releases the victim and grants.
// One request at a time: cmd_stall drops as the result enters the output register,
// which waits while res_stall holds the previous result.
// Reset: an init pass loads the free FIFO in index order and clears priorities, stall high.
// ----------------------------------------------------------------------------
// voice_allocator_priority_preempt
// Voice slot allocator: free slots come from a FIFO, held slots are kept in
// acquisition order; an acquire with no free slot preempts the oldest held
// slot of lower priority.
// ----------------------------------------------------------------------------
module voice_allocator_priority_preempt
	import vap_pkg::*;
#(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  logic [CMD_W-1:0]  command,
	input  logic [PRIO_W-1:0] priority_req,
	input  logic [SLOT_W-1:0] slot,
	output logic              res_valid,
	input  logic              res_stall,
	output logic [STAT_W-1:0] status,
	output logic [SLOT_W-1:0] granted_slot,
	output logic              preempted,
	output logic [SLOT_W-1:0] preempted_slot
);

	ctl_t ctl;
	sts_t sts;

	// sequencer
	vap_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.sts       (sts),
		.ctl       (ctl)
	);

	// storage and result register
	vap_dp #(
		.NUM_SLOTS (NUM_SLOTS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (ctl),
		.sts            (sts),
		.command        (command),
		.priority_req   (priority_req),
		.slot           (slot),
		.res_stall      (res_stall),
		.res_valid      (res_valid),
		.status         (status),
		.granted_slot   (granted_slot),
		.preempted      (preempted),
		.preempted_slot (preempted_slot)
	);

endmodule

>>> hw/rtl/vap_ctrl.sv
// ----------------------------------------------------------------------------
// vap_ctrl
// Sequencer of the allocator: init pass, request decode, held list scans,
// list compaction, release, grant and result hand-off.
// ----------------------------------------------------------------------------
module vap_ctrl
	import vap_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   cmd_valid,
	output logic   cmd_stall,
	input  sts_t   sts,
	output ctl_t   ctl
);

	state_t state_q, state_d;

	// hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_INIT: begin
				if (sts.init_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (cmd_valid) state_d = S_DECODE;
			end
			S_DECODE: begin
				priority if (sts.is_acquire) begin
					state_d = sts.free_empty ? S_ASCAN_A : S_GRANT_RD;
				end else if (sts.is_free && sts.slot_ok && sts.slot_held) begin
					state_d = S_FSCAN_A;
				end else begin
					state_d = S_DONE;
				end
			end
			S_ASCAN_A: state_d = sts.pos_at_end ? S_DONE : S_ASCAN_B;
			S_ASCAN_B: state_d = S_ASCAN_C;
			S_ASCAN_C: state_d = sts.prio_lt ? S_SHIFT_RD : S_ASCAN_A;
			S_FSCAN_A: state_d = S_FSCAN_B;
			S_FSCAN_B: state_d = sts.match ? S_SHIFT_RD : S_FSCAN_A;
			S_SHIFT_RD: state_d = sts.next_at_end ? S_RELEASE : S_SHIFT_WR;
			S_SHIFT_WR: state_d = S_SHIFT_RD;
			S_RELEASE: state_d = sts.is_acquire ? S_GRANT_RD : S_DONE;
			S_GRANT_RD: state_d = S_GRANT;
			S_GRANT: state_d = S_DONE;
			S_DONE: begin
				if (sts.out_free) state_d = S_IDLE;
			end
			default: state_d = S_INIT;
		endcase
	end

	// drive datapath commands
	always_comb begin
		ctl = '0;
		cmd_stall = (state_q != S_IDLE);
		unique case (state_q)
			S_INIT: ctl.init_wr = 1'b1;
			S_IDLE: ctl.load = cmd_valid;
			S_DECODE: begin
				if (sts.is_free && !(sts.slot_ok && sts.slot_held)) ctl.st_bad = 1'b1;
				if (sts.is_set) begin
					ctl.set_prio = sts.slot_ok;
					ctl.st_bad   = !sts.slot_ok;
				end
			end
			S_ASCAN_A: begin
				ctl.st_none = sts.pos_at_end;
				ctl.held_rd = !sts.pos_at_end;
			end
			S_ASCAN_B: ctl.prio_rd = 1'b1;
			S_ASCAN_C: begin
				ctl.vic_scan = sts.prio_lt;
				ctl.pos_inc  = !sts.prio_lt;
			end
			S_FSCAN_A: ctl.held_rd = 1'b1;
			S_FSCAN_B: begin
				ctl.vic_free = sts.match;
				ctl.pos_inc  = !sts.match;
			end
			S_SHIFT_RD: ctl.held_rd_next = !sts.next_at_end;
			S_SHIFT_WR: begin
				ctl.shift_wr = 1'b1;
				ctl.pos_inc  = 1'b1;
			end
			S_RELEASE: ctl.release_vic = 1'b1;
			S_GRANT_RD: ctl.fifo_rd = 1'b1;
			S_GRANT: ctl.grant = 1'b1;
			S_DONE: ctl.res_load = sts.out_free;
			default: ctl = '0;
		endcase
	end

endmodule

>>> hw/rtl/vap_dp.sv
// ----------------------------------------------------------------------------
// vap_dp
// Datapath of the allocator: free slot FIFO, held list and priority
// memories, held flags, counters, request latch and result register.
// ----------------------------------------------------------------------------
module vap_dp
	import vap_pkg::*;
#(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ctl_t              ctl,
	output sts_t              sts,
	input  logic [CMD_W-1:0]  command,
	input  logic [PRIO_W-1:0] priority_req,
	input  logic [SLOT_W-1:0] slot,
	input  logic              res_stall,
	output logic              res_valid,
	output logic [STAT_W-1:0] status,
	output logic [SLOT_W-1:0] granted_slot,
	output logic              preempted,
	output logic [SLOT_W-1:0] preempted_slot
);

	localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CNT_W = $clog2(NUM_SLOTS + 1);
	localparam int TW    = CNT_W + 1;
	localparam logic [SLOT_W:0]  SLOT_LIM = (SLOT_W + 1)'(NUM_SLOTS);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_SLOTS - 1);

	// storage
	logic [SLOT_W-1:0] fifo_mem [NUM_SLOTS];
	logic [SLOT_W-1:0] held_mem [NUM_SLOTS];
	logic [PRIO_W-1:0] prio_mem [NUM_SLOTS];
	logic [NUM_SLOTS-1:0] held_q;

	logic [IDX_W-1:0]  init_q;
	logic [IDX_W-1:0]  fifo_head_q;
	logic [CNT_W-1:0]  free_count_q;
	logic [CNT_W-1:0]  held_count_q;
	logic [CNT_W-1:0]  pos_q;

	logic [SLOT_W-1:0] fifo_rdata_q;
	logic [SLOT_W-1:0] held_rdata_q;
	logic [PRIO_W-1:0] prio_rdata_q;

	logic [CMD_W-1:0]  cmd_q;
	logic [PRIO_W-1:0] prio_q;
	logic [SLOT_W-1:0] slot_q;

	logic [STAT_W-1:0] st_q;
	logic [SLOT_W-1:0] gr_q;
	logic              pre_q;
	logic [SLOT_W-1:0] vic_q;

	logic              res_valid_q;
	logic [STAT_W-1:0] res_status_q;
	logic [SLOT_W-1:0] res_granted_q;
	logic              res_pre_q;
	logic [SLOT_W-1:0] res_pre_slot_q;

	logic [CNT_W-1:0]  pos_nx;
	logic [TW-1:0]     tail_sum;
	logic [IDX_W-1:0]  tail_idx;
	logic [IDX_W-1:0]  held_raddr;
	logic              slot_ok;

	assign pos_nx   = pos_q + CNT_W'(1);
	assign tail_sum = TW'(fifo_head_q) + TW'(free_count_q);
	assign tail_idx = (tail_sum >= TW'(NUM_SLOTS)) ? IDX_W'(tail_sum - TW'(NUM_SLOTS))
	                                              : IDX_W'(tail_sum);
	assign held_raddr = ctl.held_rd_next ? pos_nx[IDX_W-1:0] : pos_q[IDX_W-1:0];
	assign slot_ok  = ({1'b0, slot_q} < SLOT_LIM);

	// status toward the controller
	always_comb begin
		sts.init_last   = (init_q == IDX_LAST);
		sts.is_acquire  = (cmd_q == CMD_ACQUIRE);
		sts.is_free     = (cmd_q == CMD_FREE);
		sts.is_set      = (cmd_q == CMD_SET_PRIO);
		sts.slot_ok     = slot_ok;
		sts.slot_held   = slot_ok && held_q[slot_q[IDX_W-1:0]];
		sts.free_empty  = (free_count_q == '0);
		sts.pos_at_end  = (pos_q == held_count_q);
		sts.next_at_end = (pos_nx >= held_count_q);
		sts.prio_lt     = (prio_rdata_q < prio_q);
		sts.match       = (held_rdata_q == slot_q);
		sts.out_free    = !res_valid_q || !res_stall;
	end

	// free FIFO memory: init pass, release push, grant pop read
	always_ff @(posedge clk) begin
		if (ctl.init_wr) begin
			fifo_mem[init_q] <= SLOT_W'(init_q);
		end else if (ctl.release_vic) begin
			fifo_mem[tail_idx] <= vic_q;
		end
		if (ctl.fifo_rd) begin
			fifo_rdata_q <= fifo_mem[fifo_head_q];
		end
	end

	// held list memory: compaction shift and grant append
	always_ff @(posedge clk) begin
		if (ctl.shift_wr) begin
			held_mem[pos_q[IDX_W-1:0]] <= held_rdata_q;
		end else if (ctl.grant) begin
			held_mem[held_count_q[IDX_W-1:0]] <= fifo_rdata_q;
		end
		if (ctl.held_rd || ctl.held_rd_next) begin
			held_rdata_q <= held_mem[held_raddr];
		end
	end

	// priority memory: cleared by the init pass, written by set priority and grant
	always_ff @(posedge clk) begin
		if (ctl.init_wr) begin
			prio_mem[init_q] <= '0;
		end else if (ctl.set_prio) begin
			prio_mem[slot_q[IDX_W-1:0]] <= prio_q;
		end else if (ctl.grant) begin
			prio_mem[fifo_rdata_q[IDX_W-1:0]] <= prio_q;
		end
		if (ctl.prio_rd) begin
			prio_rdata_q <= prio_mem[held_rdata_q[IDX_W-1:0]];
		end
	end

	// advance init counter, FIFO pointers, held count, held flags and scan position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q       <= '0;
			fifo_head_q  <= '0;
			free_count_q <= CNT_W'(NUM_SLOTS);
			held_count_q <= '0;
			pos_q        <= '0;
			held_q       <= '0;
		end else begin
			if (ctl.init_wr && (init_q != IDX_LAST)) begin
				init_q <= init_q + IDX_W'(1);
			end
			if (ctl.load) begin
				pos_q <= '0;
			end else if (ctl.pos_inc) begin
				pos_q <= pos_nx;
			end
			if (ctl.release_vic) begin
				held_count_q               <= held_count_q - CNT_W'(1);
				free_count_q               <= free_count_q + CNT_W'(1);
				held_q[vic_q[IDX_W-1:0]]   <= 1'b0;
			end else if (ctl.grant) begin
				held_count_q               <= held_count_q + CNT_W'(1);
				free_count_q               <= free_count_q - CNT_W'(1);
				fifo_head_q                <= (fifo_head_q == IDX_LAST) ? '0
				                              : fifo_head_q + IDX_W'(1);
				held_q[fifo_rdata_q[IDX_W-1:0]] <= 1'b1;
			end
		end
	end

	// latch request and build the result
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q  <= command;
			prio_q <= priority_req;
			slot_q <= slot;
			st_q   <= STAT_OK;
			gr_q   <= '0;
			pre_q  <= 1'b0;
			vic_q  <= '0;
		end else begin
			if (ctl.st_none) st_q <= STAT_NONE;
			if (ctl.st_bad)  st_q <= STAT_BAD;
			if (ctl.vic_scan) begin
				vic_q <= held_rdata_q;
				pre_q <= 1'b1;
			end
			if (ctl.vic_free) vic_q <= slot_q;
			if (ctl.grant)    gr_q  <= fifo_rdata_q;
		end
	end

	// result register: hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (ctl.res_load) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.res_load) begin
			res_status_q   <= st_q;
			res_granted_q  <= gr_q;
			res_pre_q      <= pre_q;
			res_pre_slot_q <= pre_q ? vic_q : '0;
		end
	end

	assign res_valid      = res_valid_q;
	assign status         = res_status_q;
	assign granted_slot   = res_granted_q;
	assign preempted      = res_pre_q;
	assign preempted_slot = res_pre_slot_q;

endmodule

>>> hw/rtl/vap_checker.sv
// ----------------------------------------------------------------------------
// vap_checker
// Port-level checks of the allocator: result hold under stall and
// consistency of the result fields.
// ----------------------------------------------------------------------------
module vap_checker
	import vap_pkg::*;
#(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
	input logic              clk,
	input logic              arst_n,
	input logic              res_valid,
	input logic              res_stall,
	input logic [STAT_W-1:0] status,
	input logic [SLOT_W-1:0] granted_slot,
	input logic              preempted,
	input logic [SLOT_W-1:0] preempted_slot
);

	localparam logic [SLOT_W:0] SLOT_LIM = (SLOT_W + 1)'(NUM_SLOTS);

	// a stalled result holds its fields
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(status) && $stable(granted_slot)
			&& $stable(preempted) && $stable(preempted_slot))
		else $error("result changed while stalled");

	// a preempting acquire grants the slot it took
	a_pre_grant: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && preempted |-> status == STAT_OK && granted_slot == preempted_slot)
		else $error("preempted slot not granted");

	// failed requests carry no grant and no preemption
	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (status == STAT_NONE || status == STAT_BAD)
			|-> granted_slot == '0 && !preempted && preempted_slot == '0)
		else $error("failed request reports a slot");

	// granted slots stay inside the pool
	a_grant_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> {1'b0, granted_slot} < SLOT_LIM)
		else $error("granted slot out of range");

endmodule

bind voice_allocator_priority_preempt vap_checker #(
	.NUM_SLOTS (NUM_SLOTS)
) u_vap_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.res_valid      (res_valid),
	.res_stall      (res_stall),
	.status         (status),
	.granted_slot   (granted_slot),
	.preempted      (preempted),
	.preempted_slot (preempted_slot)
);

>>> dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the voice slot allocator. A short table of
// requests covers reset order, the field extremes, bad slots, preemption and
// the no-victim case. Random traffic follows, mostly frees of held slots and
// acquires against a nearly full pool. A local model of the free FIFO and
// the held list predicts each result. Both sides idle and stall in phases.
// ----------------------------------------------------------------------------
module testbench;
	import vap_pkg::*;

	localparam int NSLOT = NUM_SLOTS_DEF;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int HOLD_CYCLES = 600;
	localparam int PHASE_ITEMS = 255;
	localparam int NUM_PHASES = 6;
	localparam int PRESSURE_PHASE = 4;
	localparam int TAIL_CYCLES = 700;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [SLOT_W-1:0] granted;
		logic              pre;
		logic [SLOT_W-1:0] pre_slot;
	} alloc_res_t;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [PRIO_W-1:0] prio;
		logic [SLOT_W-1:0] slot;
		logic [7:0]        reps;
		logic              typed;
		alloc_res_t        res;
	} dir_row_t;

	// directed requests; typed rows carry their result, the rest use the model
	localparam dir_row_t DIR_TAB [24] = '{
		'{CMD_ACQUIRE,  32'd0,          8'd0,   8'd1,  1'b1, '{STAT_OK,   8'd0,  1'b0, 8'd0}},
		'{CMD_ACQUIRE,  32'hFFFF_FFFF,  8'd255, 8'd1,  1'b1, '{STAT_OK,   8'd1,  1'b0, 8'd0}},
		'{CMD_FREE,     32'd0,          8'd255, 8'd1,  1'b1, '{STAT_BAD,  8'd0,  1'b0, 8'd0}},
		'{CMD_FREE,     32'd0,          8'd96,  8'd1,  1'b1, '{STAT_BAD,  8'd0,  1'b0, 8'd0}},
		'{CMD_SET_PRIO, 32'd5,          8'd255, 8'd1,  1'b1, '{STAT_BAD,  8'd0,  1'b0, 8'd0}},
		'{CMD_SET_PRIO, 32'd5,          8'd96,  8'd1,  1'b1, '{STAT_BAD,  8'd0,  1'b0, 8'd0}},
		'{CMD_FREE,     32'd0,          8'd5,   8'd1,  1'b1, '{STAT_BAD,  8'd0,  1'b0, 8'd0}},
		'{CMD_SET_PRIO, 32'hFFFF_FFFF,  8'd95,  8'd1,  1'b1, '{STAT_OK,   8'd0,  1'b0, 8'd0}},
		'{CMD_UNUSED,   32'hFFFF_FFFF,  8'd255, 8'd1,  1'b1, '{STAT_OK,   8'd0,  1'b0, 8'd0}},
		'{CMD_FREE,     32'd0,          8'd0,   8'd1,  1'b1, '{STAT_OK,   8'd0,  1'b0, 8'd0}},
		'{CMD_FREE,     32'd0,          8'd0,   8'd1,  1'b1, '{STAT_BAD,  8'd0,  1'b0, 8'd0}},
		'{CMD_SET_PRIO, 32'd0,          8'd1,   8'd1,  1'b1, '{STAT_OK,   8'd0,  1'b0, 8'd0}},
		'{CMD_ACQUIRE,  32'd100,        8'd0,   8'd95, 1'b0, '{STAT_OK,   8'd0,  1'b0, 8'd0}},
		'{CMD_ACQUIRE,  32'd0,          8'd0,   8'd1,  1'b1, '{STAT_NONE, 8'd0,  1'b0, 8'd0}},
		'{CMD_ACQUIRE,  32'd100,        8'd0,   8'd1,  1'b0, '{STAT_OK,   8'd0,  1'b0, 8'd0}},
		'{CMD_ACQUIRE,  32'd100,        8'd0,   8'd1,  1'b1, '{STAT_NONE, 8'd0,  1'b0, 8'd0}},
		'{CMD_SET_PRIO, 32'd7,          8'd50,  8'd1,  1'b1, '{STAT_OK,   8'd0,  1'b0, 8'd0}},
		'{CMD_ACQUIRE,  32'd8,          8'd0,   8'd1,  1'b0, '{STAT_OK,   8'd0,  1'b0, 8'd0}},
		'{CMD_ACQUIRE,  32'hFFFF_FFFF,  8'd0,   8'd1,  1'b0, '{STAT_OK,   8'd0,  1'b0, 8'd0}},
		'{CMD_FREE,     32'd0,          8'd0,   8'd1,  1'b0, '{STAT_OK,   8'd0,  1'b0, 8'd0}},
		'{CMD_FREE,     32'd0,          8'd2,   8'd1,  1'b0, '{STAT_OK,   8'd0,  1'b0, 8'd0}},
		'{CMD_ACQUIRE,  32'd0,          8'd170, 8'd1,  1'b0, '{STAT_OK,   8'd0,  1'b0, 8'd0}},
		'{CMD_FREE,     32'd0,          8'd3,   8'd1,  1'b0, '{STAT_OK,   8'd0,  1'b0, 8'd0}},
		'{CMD_SET_PRIO, 32'd0,          8'd3,   8'd1,  1'b0, '{STAT_OK,   8'd0,  1'b0, 8'd0}}
	};

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cmd_valid = 1'b0;
	logic              cmd_stall;
	logic [CMD_W-1:0]  command = '0;
	logic [PRIO_W-1:0] priority_req = '0;
	logic [SLOT_W-1:0] slot = '0;
	logic              res_valid;
	logic              res_stall = 1'b0;
	logic [STAT_W-1:0] status;
	logic [SLOT_W-1:0] granted_slot;
	logic              preempted;
	logic [SLOT_W-1:0] preempted_slot;

	// allocator model state
	logic [SLOT_W-1:0] free_slots [$];
	logic [SLOT_W-1:0] held_order [$];
	logic [PRIO_W-1:0] slot_prio [NSLOT];
	bit                slot_busy [NSLOT];

	alloc_res_t pending_res [$];
	alloc_res_t mon_want;
	int         err_cnt = 0;
	int         res_idx = 0;
	int         send_idle_pct = 0;
	int         recv_stall_pct = 0;
	int         hold_req_cnt = 0;
	int         hold_ack_cnt = 0;
	int         hold_left = 0;

	voice_allocator_priority_preempt #(
		.NUM_SLOTS(NSLOT)
	) u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (cmd_valid),
		.cmd_stall     (cmd_stall),
		.command       (command),
		.priority_req  (priority_req),
		.slot          (slot),
		.res_valid     (res_valid),
		.res_stall     (res_stall),
		.status        (status),
		.granted_slot  (granted_slot),
		.preempted     (preempted),
		.preempted_slot(preempted_slot)
	);

	always #6 clk = ~clk;

	// predict one request and advance the pool model
	function automatic alloc_res_t predict_alloc(logic [CMD_W-1:0] c, logic [PRIO_W-1:0] p,
			logic [SLOT_W-1:0] s);
		alloc_res_t   r;
		logic [SLOT_W-1:0] g;
		bit           found;
		r = '0;
		found = 1'b0;
		case (c)
			CMD_ACQUIRE: begin
				// with no free slot, preempt the oldest held slot of lower priority
				if (free_slots.size() == 0) begin
					for (int i = 0; i < held_order.size() && !found; i++) begin
						if (slot_prio[held_order[i]] < p) begin
							found = 1'b1;
							r.pre = 1'b1;
							r.pre_slot = held_order[i];
							slot_busy[held_order[i]] = 1'b0;
							free_slots.insert(free_slots.size(), held_order[i]);
							held_order.delete(i);
						end
					end
				end
				if (free_slots.size() == 0) begin
					r.status = STAT_NONE;
				end else begin
					g = free_slots.pop_front();
					slot_prio[g] = p;
					slot_busy[g] = 1'b1;
					held_order.insert(held_order.size(), g);
					r.granted = g;
				end
			end
			CMD_FREE: begin
				if (s >= NSLOT || !slot_busy[s]) begin
					r.status = STAT_BAD;
				end else begin
					for (int i = 0; i < held_order.size() && !found; i++) begin
						if (held_order[i] == s) begin
							found = 1'b1;
							held_order.delete(i);
						end
					end
					slot_busy[s] = 1'b0;
					free_slots.insert(free_slots.size(), s);
				end
			end
			CMD_SET_PRIO: begin
				if (s >= NSLOT)
					r.status = STAT_BAD;
				else
					slot_prio[s] = p;
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("MISMATCH result %0d %s: got %0h expected %0h", res_idx, what, got, want);
		err_cnt++;
	endtask

	// pick a slot index, mostly one that is held right now
	function automatic logic [SLOT_W-1:0] pick_slot(int held_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < held_pct && held_order.size() > 0)
			return held_order[$urandom_range(0, held_order.size() - 1)];
		else if (r < held_pct + 15)
			return SLOT_W'($urandom_range(0, NSLOT - 1));
		else
			return SLOT_W'($urandom_range(0, 255));
	endfunction

	// drive one request from a falling edge; return at the falling edge after acceptance
	task automatic send_req(logic [CMD_W-1:0] c, logic [PRIO_W-1:0] p, logic [SLOT_W-1:0] s,
			bit typed, alloc_res_t typed_res);
		alloc_res_t pred;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			command <= CMD_W'($urandom);
			priority_req <= $urandom;
			slot <= SLOT_W'($urandom);
			@(negedge clk);
		end
		cmd_valid <= 1'b1;
		command <= c;
		priority_req <= p;
		slot <= s;
		do
			@(posedge clk);
		while (cmd_stall);
		pred = predict_alloc(c, p, s);
		pending_res.insert(pending_res.size(), typed ? typed_res : pred);
		@(negedge clk);
	endtask

	// pause the sender until every pending result is back
	task automatic drain_results();
		cmd_valid <= 1'b0;
		while (pending_res.size() != 0)
			@(negedge clk);
	endtask

	// receiver: random stall, or a long hold-off when one is requested
	always @(negedge clk) begin
		if (hold_req_cnt != hold_ack_cnt) begin
			hold_ack_cnt = hold_req_cnt;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			res_stall <= 1'b1;
		end else begin
			res_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	// check each accepted result against the oldest pending one
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (pending_res.size() == 0) begin
				report_mismatch("unexpected result, status", 32'(status), 32'(STAT_OK));
			end else begin
				mon_want = pending_res.pop_front();
				if (status !== mon_want.status)
					report_mismatch("status", 32'(status), 32'(mon_want.status));
				if (granted_slot !== mon_want.granted)
					report_mismatch("granted_slot", 32'(granted_slot), 32'(mon_want.granted));
				if (preempted !== mon_want.pre)
					report_mismatch("preempted", 32'(preempted), 32'(mon_want.pre));
				if (preempted_slot !== mon_want.pre_slot)
					report_mismatch("preempted_slot", 32'(preempted_slot),
						32'(mon_want.pre_slot));
			end
			res_idx++;
		end
	end

	initial begin
		logic [CMD_W-1:0]  c;
		logic [PRIO_W-1:0] p;
		logic [SLOT_W-1:0] s;
		int                r;
		// reset model: free FIFO in index order, nothing held
		for (int i = 0; i < NSLOT; i++) begin
			free_slots.insert(free_slots.size(), SLOT_W'(i));
			slot_prio[i] = '0;
			slot_busy[i] = 1'b0;
		end
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// walk the directed table
		for (int k = 0; k < $size(DIR_TAB); k++) begin
			for (int n = 0; n < DIR_TAB[k].reps; n++)
				send_req(DIR_TAB[k].cmd, DIR_TAB[k].prio, DIR_TAB[k].slot,
					DIR_TAB[k].typed, DIR_TAB[k].res);
		end
		drain_results();

		// random traffic in idling phases
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
				1: begin send_idle_pct = 87; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 87; end
				3: begin send_idle_pct = 34; recv_stall_pct = 34; end
				default: begin send_idle_pct = 0; recv_stall_pct = 0; end
			endcase
			if (ph == PRESSURE_PHASE)
				hold_req_cnt++;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				r = $urandom_range(0, 99);
				s = SLOT_W'($urandom_range(0, 255));
				case ($urandom_range(0, 9))
					8: p = '0;
					9: p = '1;
					6, 7: p = $urandom;
					default: p = PRIO_W'($urandom_range(0, 7));
				endcase
				if (r < 47) begin
					c = CMD_ACQUIRE;
				end else if (r < 77) begin
					c = CMD_FREE;
					s = pick_slot(70);
				end else if (r < 97) begin
					c = CMD_SET_PRIO;
					s = pick_slot(60);
				end else begin
					c = CMD_UNUSED;
				end
				send_req(c, p, s, 1'b0, '0);
			end
			drain_results();
		end

		// let any stray result show up
		repeat (TAIL_CYCLES) @(negedge clk);
		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// stop a hung run
	initial begin
		#150_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

>>> files.f
hw/rtl/vap_pkg.sv
hw/rtl/vap_ctrl.sv
hw/rtl/vap_dp.sv
hw/rtl/voice_allocator_priority_preempt.sv
hw/rtl/vap_checker.sv
dv/testbench.sv
